FILE: design/p2r_pkg.sv
// Shared constants and the forward-scale table for the point-to-rectangle distance block.
// No dependencies.
package p2r_pkg;
   localparam int X_W     = 26;
   localparam int Y_W     = 25;
   localparam int DIST_W  = 26;
   localparam int DX_W    = X_W + 1;
   localparam int DY_W    = Y_W + 1;
   localparam int IDX_W   = 9;
   localparam int ROM_W   = 13;
   localparam int ROM_DEPTH = 138;
   localparam int ROM_AW  = 8;
   localparam int PROD_W  = DX_W + ROM_W + 1;

   localparam logic [ROM_W-1:0] FWD_ROM [0:ROM_DEPTH-1] = '{
      13'd4559,13'd4558,13'd4557,13'd4556,13'd4554,13'd4551,13'd4548,13'd4544,13'd4539,
      13'd4534,13'd4529,13'd4522,13'd4516,13'd4508,13'd4500,13'd4492,13'd4482,13'd4473,
      13'd4462,13'd4451,13'd4440,13'd4428,13'd4415,13'd4402,13'd4388,13'd4373,13'd4358,
      13'd4343,13'd4327,13'd4310,13'd4293,13'd4275,13'd4257,13'd4238,13'd4218,13'd4198,
      13'd4177,13'd4156,13'd4135,13'd4112,13'd4090,13'd4066,13'd4042,13'd4018,13'd3993,
      13'd3968,13'd3942,13'd3915,13'd3888,13'd3861,13'd3833,13'd3805,13'd3776,13'd3746,
      13'd3716,13'd3686,13'd3655,13'd3623,13'd3592,13'd3559,13'd3526,13'd3493,13'd3459,
      13'd3425,13'd3391,13'd3355,13'd3320,13'd3284,13'd3248,13'd3211,13'd3174,13'd3136,
      13'd3098,13'd3059,13'd3021,13'd2981,13'd2942,13'd2902,13'd2861,13'd2820,13'd2779,
      13'd2738,13'd2696,13'd2654,13'd2611,13'd2568,13'd2525,13'd2481,13'd2438,13'd2393,
      13'd2349,13'd2304,13'd2259,13'd2213,13'd2168,13'd2122,13'd2075,13'd2029,13'd1982,
      13'd1935,13'd1887,13'd1840,13'd1792,13'd1744,13'd1696,13'd1647,13'd1598,13'd1550,
      13'd1500,13'd1451,13'd1402,13'd1352,13'd1302,13'd1252,13'd1202,13'd1151,13'd1101,
      13'd1050,13'd999,13'd948,13'd897,13'd846,13'd795,13'd743,13'd692,13'd640,
      13'd589,13'd537,13'd485,13'd433,13'd381,13'd329,13'd277,13'd225,13'd173,
      13'd121,13'd69,13'd17
   };
endpackage

FILE: design/p2r_req_if.sv
// Request and response channel interfaces for the distance block.
// Depends on p2r_pkg.
interface p2r_req_if import p2r_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic signed [X_W-1:0]  point_x;
   logic signed [Y_W-1:0]  point_y;
   logic signed [X_W-1:0]  box_x_low;
   logic signed [Y_W-1:0]  box_y_low;
   logic signed [X_W-1:0]  box_x_high;
   logic signed [Y_W-1:0]  box_y_high;
   modport source (output valid, point_x, point_y, box_x_low, box_y_low, box_x_high,
                   box_y_high, input ready);
   modport sink (input valid, point_x, point_y, box_x_low, box_y_low, box_x_high,
                 box_y_high, output ready);
endinterface

interface p2r_rsp_if import p2r_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DIST_W-1:0] distance_metres;
   modport source (output valid, distance_metres, input ready);
   modport sink (input valid, distance_metres, output ready);
endinterface

FILE: design/point_to_rect_distance.sv
// Point-to-rectangle distance, equirectangular scaling, floor square root.
// Throughput one word per cycle while the response channel is not stalled.
// Every stage holds its word under backpressure and refills bubbles independently.
// Synchronous active-high reset clears all valid bits; payload is not reset.
// Depends on p2r_pkg, p2r_req_if, p2r_rsp_if, p2r_front, p2r_sqrt.
module point_to_rect_distance import p2r_pkg::*; #(
   parameter int SCALE_ENTRIES = 138,
   parameter int FRACTION_BITS = 12
) (
   input  logic      clock,
   input  logic      reset,
   p2r_req_if.sink   req_port,
   p2r_rsp_if.source rsp_port
);
   localparam int MAG_W  = PROD_W - 1 - FRACTION_BITS;
   localparam int ROOT_W = MAG_W + 1;

   logic                f_valid, f_ready;
   logic [2*MAG_W:0]    f_sum;
   logic [ROOT_W-1:0]   root;

   p2r_front #(
      .SCALE_ENTRIES(SCALE_ENTRIES),
      .FRACTION_BITS(FRACTION_BITS),
      .MAG_W(MAG_W)
   ) u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_port.valid), .in_ready(req_port.ready),
      .px(req_port.point_x), .py(req_port.point_y),
      .xl(req_port.box_x_low), .yl(req_port.box_y_low),
      .xh(req_port.box_x_high), .yh(req_port.box_y_high),
      .out_valid(f_valid), .out_ready(f_ready), .out_sum(f_sum)
   );

   p2r_sqrt #(.ROOT_W(ROOT_W)) u_sqrt (
      .clock(clock), .reset(reset),
      .in_valid(f_valid), .in_ready(f_ready),
      .in_value((2*ROOT_W)'(f_sum)),
      .out_valid(rsp_port.valid), .out_ready(rsp_port.ready), .out_root(root)
   );

   if (ROOT_W > DIST_W) begin : g_sat
      assign rsp_port.distance_metres = (|root[ROOT_W-1:DIST_W]) ? '1 : root[DIST_W-1:0];
   end else begin : g_ext
      assign rsp_port.distance_metres = DIST_W'(root);
   end

   a_reset_empty: assert property (@(posedge clock) $past(reset) |-> !rsp_port.valid)
      else $error("response valid right after reset");
   a_front_hold: assert property (@(posedge clock) disable iff (reset)
      f_valid && !f_ready |=> f_valid && $stable(f_sum))
      else $error("front word dropped or changed under stall");
   a_accept_path: assert property (@(posedge clock) disable iff (reset)
      rsp_port.ready |-> req_port.ready)
      else $error("input stalled while output drains");
endmodule

FILE: design/p2r_front.sv
// Clamp, scale-table lookup, scaling multiplies and sum of squares, six stages.
// Depends on p2r_pkg.
module p2r_front import p2r_pkg::*; #(
   parameter int SCALE_ENTRIES = 138,
   parameter int FRACTION_BITS = 12,
   parameter int MAG_W = 28
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic signed [X_W-1:0]         px,
   input  logic signed [Y_W-1:0]         py,
   input  logic signed [X_W-1:0]         xl,
   input  logic signed [Y_W-1:0]         yl,
   input  logic signed [X_W-1:0]         xh,
   input  logic signed [Y_W-1:0]         yh,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [2*MAG_W:0]              out_sum
);
   localparam int NS = 6;
   localparam int SH_W = PROD_W - FRACTION_BITS;
   localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(SCALE_ENTRIES - 1);

   logic [NS-1:0] v_ff, v_in;
   logic [NS:0]   rdy;

   logic                   inside0_ff, inside1_ff, inside2_ff;
   logic signed [DX_W-1:0] dx0_ff, dx1_ff;
   logic signed [DY_W-1:0] dy0_ff, dy1_ff;
   logic signed [Y_W:0]    csum0_ff;
   logic [ROM_W-1:0]       scale1_ff;
   logic signed [PROD_W-1:0] prodx2_ff, prody2_ff;
   logic [MAG_W-1:0]       magx3_ff, magy3_ff;
   logic [2*MAG_W-1:0]     sqx4_ff, sqy4_ff;
   logic [2*MAG_W:0]       sum5_ff;

   logic signed [X_W-1:0]  cx;
   logic signed [Y_W-1:0]  cy;
   logic                   xin, yin;
   logic signed [Y_W:0]    cadj;
   logic signed [Y_W-1:0]  centre;
   logic [Y_W-1:0]         cabs;
   logic [IDX_W-1:0]       idx, idx_sat;
   logic [ROM_W-1:0]       scale;
   logic signed [SH_W-1:0] qx, qy;
   logic [SH_W-1:0]        ax, ay;

   always_comb begin
      rdy[NS] = out_ready;
      for (int i = NS - 1; i >= 0; i--) begin
         rdy[i] = !v_ff[i] || rdy[i+1];
      end
      v_in[0] = rdy[0] ? in_valid : v_ff[0];
      for (int i = 1; i < NS; i++) begin
         v_in[i] = rdy[i] ? v_ff[i-1] : v_ff[i];
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = v_ff[NS-1];
   assign out_sum   = sum5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_comb begin
      xin = 1'b0;
      yin = 1'b0;
      if (px < xl) begin
         cx = xl;
      end else if (px > xh) begin
         cx = xh;
      end else begin
         cx  = px;
         xin = 1'b1;
      end
      if (py < yl) begin
         cy = yl;
      end else if (py > yh) begin
         cy = yh;
      end else begin
         cy  = py;
         yin = 1'b1;
      end
   end

   always_comb begin
      cadj    = csum0_ff + {{Y_W{1'b0}}, csum0_ff[Y_W]};
      centre  = Y_W'(cadj >>> 1);
      cabs    = centre[Y_W-1] ? Y_W'(-centre) : Y_W'(centre);
      idx     = IDX_W'(cabs >> 16);
      idx_sat = (idx > IDX_MAX) ? IDX_MAX : idx;
      scale   = (idx_sat >= IDX_W'(ROM_DEPTH)) ? '0 : FWD_ROM[idx_sat[ROM_AW-1:0]];
      qx      = SH_W'(prodx2_ff >>> FRACTION_BITS);
      qy      = SH_W'(prody2_ff >>> FRACTION_BITS);
      ax      = qx[SH_W-1] ? SH_W'(-qx) : SH_W'(qx);
      ay      = qy[SH_W-1] ? SH_W'(-qy) : SH_W'(qy);
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         inside0_ff <= xin && yin;
         dx0_ff     <= DX_W'(cx) - DX_W'(px);
         dy0_ff     <= DY_W'(cy) - DY_W'(py);
         csum0_ff   <= (Y_W+1)'(cy) + (Y_W+1)'(py);
      end
      if (rdy[1]) begin
         inside1_ff <= inside0_ff;
         dx1_ff     <= dx0_ff;
         dy1_ff     <= dy0_ff;
         scale1_ff  <= scale;
      end
      if (rdy[2]) begin
         inside2_ff <= inside1_ff;
         prodx2_ff  <= PROD_W'(dx1_ff) * $signed({1'b0, scale1_ff});
         prody2_ff  <= PROD_W'(dy1_ff) * $signed({1'b0, FWD_ROM[0]});
      end
      if (rdy[3]) begin
         magx3_ff <= inside2_ff ? '0 : MAG_W'(ax);
         magy3_ff <= inside2_ff ? '0 : MAG_W'(ay);
      end
      if (rdy[4]) begin
         sqx4_ff <= (2*MAG_W)'(magx3_ff) * (2*MAG_W)'(magx3_ff);
         sqy4_ff <= (2*MAG_W)'(magy3_ff) * (2*MAG_W)'(magy3_ff);
      end
      if (rdy[5]) begin
         sum5_ff <= (2*MAG_W+1)'(sqx4_ff) + (2*MAG_W+1)'(sqy4_ff);
      end
   end
endmodule

FILE: design/p2r_sqrt.sv
// Pipelined floor square root, one root bit per stage.
// Depends on p2r_pkg for house conventions only.
module p2r_sqrt import p2r_pkg::*; #(
   parameter int ROOT_W = 29
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [2*ROOT_W-1:0]   in_value,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [ROOT_W-1:0]     out_root
);
   localparam int SQ_W  = 2 * ROOT_W;
   localparam int REM_W = ROOT_W + 2;

   logic [ROOT_W-1:0] v_ff, v_in;
   logic [ROOT_W:0]   rdy;
   logic [REM_W-1:0]  rem_ff  [0:ROOT_W-1];
   logic [ROOT_W-1:0] root_ff [0:ROOT_W-1];
   logic [SQ_W-1:0]   rest_ff [0:ROOT_W-1];

   always_comb begin
      rdy[ROOT_W] = out_ready;
      for (int i = ROOT_W - 1; i >= 0; i--) begin
         rdy[i] = !v_ff[i] || rdy[i+1];
      end
      v_in[0] = rdy[0] ? in_valid : v_ff[0];
      for (int i = 1; i < ROOT_W; i++) begin
         v_in[i] = rdy[i] ? v_ff[i-1] : v_ff[i];
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = v_ff[ROOT_W-1];
   assign out_root  = root_ff[ROOT_W-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
      logic [REM_W-1:0]  rem_prev, rem_sh, trial;
      logic [ROOT_W-1:0] root_prev;
      logic [SQ_W-1:0]   rest_prev;
      logic              take;

      if (k == 0) begin : g_first
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign rest_prev = in_value;
      end else begin : g_next
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
         assign rest_prev = rest_ff[k-1];
      end

      always_comb begin
         rem_sh = {rem_prev[REM_W-3:0], rest_prev[SQ_W-1 -: 2]};
         trial  = {root_prev, 2'b01};
         take   = rem_sh >= trial;
      end

      always_ff @(posedge clock) begin
         if (rdy[k]) begin
            rem_ff[k]  <= take ? rem_sh - trial : rem_sh;
            root_ff[k] <= {root_prev[ROOT_W-2:0], take};
            rest_ff[k] <= {rest_prev[SQ_W-3:0], 2'b00};
         end
      end
   end
endmodule

FILE: tb/p2r_tb_if.sv
`timescale 1ns / 100ps
// Testbench-side note: channel interfaces come from the design folder (p2r_req_if, p2r_rsp_if).
// This file holds the distance predictor and scoreboard class; depends on p2r_pkg.
package p2r_tb_pkg;
   import p2r_pkg::*;

   typedef struct {
      logic signed [X_W-1:0] px;
      logic signed [Y_W-1:0] py;
      logic signed [X_W-1:0] xl;
      logic signed [Y_W-1:0] yl;
      logic signed [X_W-1:0] xh;
      logic signed [Y_W-1:0] yh;
   } query_type;

   function automatic longint unsigned scaled_mag(longint d, longint s);
      longint p;
      longint q;
      p = d * s;
      q = p >>> 12;
      return (q < 0) ? -q : q;
   endfunction

   function automatic logic [DIST_W-1:0] predict_distance(query_type w);
      longint px, py, xl, yl, xh, yh, cx, cy, mid, ix, sx;
      longint unsigned mx, my, v, res, b;
      bit xin, yin;
      px = w.px; py = w.py; xl = w.xl; yl = w.yl; xh = w.xh; yh = w.yh;
      xin = 0; yin = 0;
      if (px < xl) cx = xl;
      else if (px > xh) cx = xh;
      else begin cx = px; xin = 1; end
      if (py < yl) cy = yl;
      else if (py > yh) cy = yh;
      else begin cy = py; yin = 1; end
      if (xin && yin) return '0;
      mid = (cy + py) / 2;
      ix = ((mid < 0) ? -mid : mid) >> 16;
      if (ix > ROM_DEPTH - 1) ix = ROM_DEPTH - 1;
      sx = FWD_ROM[ix];
      mx = scaled_mag(cx - px, sx);
      my = scaled_mag(cy - py, FWD_ROM[0]);
      v = mx * mx + my * my;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      if (res > 67108863) res = 67108863;
      return res[DIST_W-1:0];
   endfunction

   class distance_scoreboard;
      logic [DIST_W-1:0] pending[$];
      int errors;

      task report(string msg);
         $display("mismatch: %s", msg);
         errors++;
      endtask

      function void note_query(query_type w);
         pending.push_back(predict_distance(w));
      endfunction

      task check_distance(logic [DIST_W-1:0] got);
         logic [DIST_W-1:0] want;
         if (pending.size() == 0) begin
            report($sformatf("unexpected distance %0d", got));
         end else begin
            want = pending.pop_front();
            if (got !== want) begin
               report($sformatf("distance_metres got %0d want %0d", got, want));
            end
         end
      endtask
   endclass
endpackage

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// Top-level testbench: drives random and corner distance queries with random stalls
// and checks every distance. Depends on p2r_pkg, p2r_tb_pkg, the channel interfaces.
module testbench;
   import p2r_pkg::*;
   import p2r_tb_pkg::*;

   localparam int XMAX = 18087935;
   localparam int YMAX = 9043967;
   localparam int LIMIT = 200000;

   logic clock = 0;
   logic reset = 1;
   int cycles = 0;
   bit calm = 0;
   int sent = 0;

   p2r_req_if req_ch();
   p2r_rsp_if rsp_ch();
   distance_scoreboard board = new();

   point_to_rect_distance dut (.clock(clock), .reset(reset), .req_port(req_ch),
                               .rsp_port(rsp_ch));

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   initial begin
      req_ch.valid = 0;
      req_ch.point_x = 0; req_ch.point_y = 0;
      req_ch.box_x_low = 0; req_ch.box_y_low = 0;
      req_ch.box_x_high = 0; req_ch.box_y_high = 0;
      rsp_ch.ready = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("testbench: errors");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) board.check_distance(rsp_ch.distance_metres);
   end

   // random receiver stalls in bursts
   initial begin : sink_side
      int n;
      @(posedge clock);
      while (1) begin
         rsp_ch.ready <= 1;
         n = $urandom_range(1, 8);
         repeat (n) @(posedge clock);
         if (!calm && $urandom_range(0, 2) == 0) begin
            rsp_ch.ready <= 0;
            n = $urandom_range(1, 5);
            repeat (n) @(posedge clock);
         end
      end
   end

   function automatic int rnd_x(int lim);
      case ($urandom_range(0, 5))
         0: return lim;
         1: return -lim - 1;
         2: return $urandom_range(0, 200000) - 100000;
         default: return $urandom_range(0, 2 * lim + 1) - lim - 1;
      endcase
   endfunction

   task automatic send(query_type w);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_ch.valid <= 1;
      req_ch.point_x <= w.px; req_ch.point_y <= w.py;
      req_ch.box_x_low <= w.xl; req_ch.box_y_low <= w.yl;
      req_ch.box_x_high <= w.xh; req_ch.box_y_high <= w.yh;
      do @(posedge clock); while (!req_ch.ready);
      board.note_query(w);
      sent++;
   endtask

   task automatic send_box(int px, int py, int xl, int yl, int xh, int yh);
      query_type w;
      w.px = X_W'(px); w.py = Y_W'(py);
      w.xl = X_W'(xl); w.yl = Y_W'(yl);
      w.xh = X_W'(xh); w.yh = Y_W'(yh);
      send(w);
   endtask

   initial begin : source_side
      query_type w;
      int a, b;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send_box(0, 0, -10, -10, 10, 10);
      send_box(10, 10, -10, -10, 10, 10);
      send_box(XMAX, YMAX, -XMAX - 1, -YMAX - 1, -XMAX - 1, -YMAX - 1);
      send_box(-XMAX - 1, -YMAX - 1, XMAX, YMAX, XMAX, YMAX);
      send_box(XMAX, -YMAX - 1, -XMAX - 1, YMAX, -XMAX - 1, YMAX);
      send_box(-1, -1, 0, 0, 0, 0);
      send_box(5, 5, 10, 10, -10, -10);
      send_box(20, 20, 10, 10, -10, -10);
      send_box(0, 5, 10, 10, -10, -10);
      send_box(100, YMAX, 0, -YMAX - 1, 50, -YMAX - 1);
      send_box(100, -YMAX - 1, 0, YMAX, 50, YMAX);
      send_box(0, 8000000, 1000, 8000000, 2000, 8000000);
      send_box(0, -8000000, 1000, -8000000, 2000, -8000000);
      send_box(0, 65536, 1000, 65536, 2000, 65536);
      send_box(0, -65537, 5, -65537, 5, -65537);
      send_box(-1, 0, 0, -1, 0, 0);
      send_box(-XMAX - 1, 0, XMAX, 0, XMAX, 0);
      send_box(0, 0, -3, -3, -1, -1);
      for (int i = 0; i < 450; i++) begin
         if (i > 380) calm = 1;
         w.px = X_W'(rnd_x(XMAX)); w.py = Y_W'(rnd_x(YMAX));
         if ($urandom_range(0, 4) != 0) begin
            a = rnd_x(XMAX); b = rnd_x(XMAX);
            w.xl = X_W'((a < b) ? a : b); w.xh = X_W'((a < b) ? b : a);
            a = rnd_x(YMAX); b = rnd_x(YMAX);
            w.yl = Y_W'((a < b) ? a : b); w.yh = Y_W'((a < b) ? b : a);
         end else begin
            w.xl = X_W'(rnd_x(XMAX)); w.xh = X_W'(rnd_x(XMAX));
            w.yl = Y_W'(rnd_x(YMAX)); w.yh = Y_W'(rnd_x(YMAX));
         end
         send(w);
      end
      req_ch.valid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (board.errors == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end
endmodule

FILE: point_to_rect_distance.f
design/p2r_pkg.sv
design/p2r_req_if.sv
design/p2r_front.sv
design/p2r_sqrt.sv
design/point_to_rect_distance.sv
tb/p2r_tb_if.sv
tb/testbench.sv
